### rtl/core/tbi_pkg.sv
// shared constants and codes for the triangle barycentric interpolator
package tbi_pkg;

  // default table depth
  localparam int unsigned MaxComponentsDefault = 8;

  // field widths
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned DiffWidth  = 17;
  localparam int unsigned AreaWidth  = 35;
  localparam int unsigned ProdWidth  = 52;
  localparam int unsigned NumWidth   = 53;
  localparam int unsigned CountWidth = 4;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
  localparam logic [1:0] STATUS_SATURATED  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_V1_X  = 3'd0;
  localparam logic [2:0] REG_V1_Y  = 3'd1;
  localparam logic [2:0] REG_V2_X  = 3'd2;
  localparam logic [2:0] REG_V2_Y  = 3'd3;
  localparam logic [2:0] REG_V3_X  = 3'd4;
  localparam logic [2:0] REG_V3_Y  = 3'd5;
  localparam logic [2:0] REG_COUNT = 3'd6;

endpackage

### rtl/core/triangle_barycentric_interpolator.sv
// triangle barycentric interpolator top level
//
//  channel   direction  payload
//  s_axis    in         tuser: kind; tdata: component, value_at_first/second/third,
//                       point_x, point_y
//  m_axis    out        tuser: status; tlast: last_of_point; tdata: result_value,
//                       result_component
//  cfg       in         cfg_index, cfg_data (always ready)
//
// a load item writes one row of the value table.
// a query computes the four areas (12 products on one shared 35x17
// multiplier), then per component a table read, three products, a setup
// step and 53 divider steps plus an output step. degenerate triangles skip
// the table and divider, one result per cycle unless the output stalls.
// reset is synchronous; the table holds no reset value. a stalled output
// holds the sequencer before the next result is written.
module triangle_barycentric_interpolator
  import tbi_pkg::*;
#(
  parameter int unsigned MAX_COMPONENTS = MaxComponentsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // component[2:0], v1[18:3], v2[34:19], v3[50:35],
                                      // point_x[66:51], point_y[82:67], zero pad
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // result_value[15:0], result_component[18:16], pad
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned KW = $clog2(MAX_COMPONENTS + 1);
  localparam int unsigned DivSteps = NumWidth;
  localparam int unsigned SW = $clog2(DivSteps + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_AREA = 7'b0000010,
    S_READ = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_PREP = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic signed [CoordWidth-1:0] vx [3];
  logic signed [CoordWidth-1:0] vy [3];
  logic [CountWidth-1:0] comp_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0;
        vy[i] <= '0;
      end
      comp_use <= CountWidth'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_V1_X:  vx[0] <= cfg_data;
        REG_V1_Y:  vy[0] <= cfg_data;
        REG_V2_X:  vx[1] <= cfg_data;
        REG_V2_Y:  vy[1] <= cfg_data;
        REG_V3_X:  vx[2] <= cfg_data;
        REG_V3_Y:  vy[2] <= cfg_data;
        REG_COUNT: comp_use <= cfg_data[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [2:0] in_comp;
  logic signed [CoordWidth-1:0] in_v [3];
  logic signed [CoordWidth-1:0] in_px, in_py;
  logic in_accept;

  assign in_comp  = s_axis_tdata[2:0];
  assign in_v[0]  = s_axis_tdata[18:3];
  assign in_v[1]  = s_axis_tdata[34:19];
  assign in_v[2]  = s_axis_tdata[50:35];
  assign in_px    = s_axis_tdata[66:51];
  assign in_py    = s_axis_tdata[82:67];
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // component count clamped to [1, MAX_COMPONENTS]
  logic [KW-1:0] count;
  always_comb begin
    if (comp_use == '0) begin
      count = KW'(1);
    end else if (32'(comp_use) > MAX_COMPONENTS) begin
      count = KW'(MAX_COMPONENTS);
    end else begin
      count = KW'(comp_use);
    end
  end

  // value table, one row per component
  logic [3*CoordWidth-1:0] table_mem [MAX_COMPONENTS];
  logic [3*CoordWidth-1:0] row;
  logic [KW-1:0] k;

  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tuser == KIND_LOAD && 32'(in_comp) < MAX_COMPONENTS) begin
      table_mem[CW'(in_comp)] <= {in_v[2], in_v[1], in_v[0]};
    end
    if (state == S_READ) begin
      row <= table_mem[CW'(k)];
    end
  end

  // query point and areas
  logic signed [CoordWidth-1:0] px, py;
  logic signed [AreaWidth-1:0] area [4];
  logic [1:0] aj, at;
  logic issue_done;

  // shared multiplier with registered product
  logic signed [AreaWidth-1:0] mul_a;
  logic signed [DiffWidth-1:0] mul_b;
  logic signed [ProdWidth-1:0] prod;
  logic prod_v;
  logic [1:0] prod_j;

  // points of the area in progress
  logic signed [CoordWidth-1:0] ptx [3];
  logic signed [CoordWidth-1:0] pty [3];
  logic signed [DiffWidth-1:0] ydiff;

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      ptx[t] = (32'(aj) == t + 1) ? px : vx[t];
      pty[t] = (32'(aj) == t + 1) ? py : vy[t];
    end
    case (at)
      2'd0:    ydiff = DiffWidth'(pty[1]) - DiffWidth'(pty[2]);
      2'd1:    ydiff = DiffWidth'(pty[2]) - DiffWidth'(pty[0]);
      default: ydiff = DiffWidth'(pty[0]) - DiffWidth'(pty[1]);
    endcase
    if (state == S_AREA) begin
      mul_a = AreaWidth'(ptx[at]);
      mul_b = ydiff;
    end else begin
      mul_a = area[at + 2'd1];
      case (at)
        2'd0:    mul_b = DiffWidth'($signed(row[15:0]));
        2'd1:    mul_b = DiffWidth'($signed(row[31:16]));
        default: mul_b = DiffWidth'($signed(row[47:32]));
      endcase
    end
  end

  // numerator and divider
  logic signed [NumWidth-1:0] num;
  logic [NumWidth-1:0] quo;
  logic [AreaWidth-1:0] rem, divisor;
  logic [AreaWidth:0] rem_sh;
  logic neg;
  logic [SW-1:0] step;

  assign rem_sh = {rem, quo[NumWidth-1]};

  // saturation of the finished quotient
  logic signed [CoordWidth-1:0] sat_val;
  logic [1:0] sat_status;
  always_comb begin
    sat_status = STATUS_OK;
    if (area[0] == '0) begin
      sat_val = '0;
      sat_status = STATUS_DEGENERATE;
    end else if (neg) begin
      if (quo > NumWidth'(32768)) begin
        sat_val = 16'sh8000;
        sat_status = STATUS_SATURATED;
      end else begin
        sat_val = -$signed(quo[CoordWidth-1:0]);
      end
    end else if (quo > NumWidth'(32767)) begin
      sat_val = 16'sh7fff;
      sat_status = STATUS_SATURATED;
    end else begin
      sat_val = $signed(quo[CoordWidth-1:0]);
    end
  end

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prod_v <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // a product is valid the cycle after its issue
      prod_v <= (state == S_AREA || state == S_MUL) && !issue_done;
      // output register loads in S_OUT and empties on a handshake
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (prod_v) begin
        if (state == S_AREA) begin
          area[prod_j] <= area[prod_j] + AreaWidth'(prod);
        end else begin
          num <= num + NumWidth'(prod);
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && s_axis_tuser == KIND_QUERY) begin
            px <= in_px;
            py <= in_py;
            for (int i = 0; i < 4; i++) begin
              area[i] <= '0;
            end
            aj <= '0;
            at <= '0;
            issue_done <= 1'b0;
            k <= '0;
            state <= S_AREA;
          end
        end
        S_AREA: begin
          if (!issue_done) begin
            prod <= ProdWidth'(mul_a * mul_b);
            prod_j <= aj;
            if (at == 2'd2) begin
              at <= '0;
              aj <= aj + 2'd1;
              issue_done <= (aj == 2'd3);
            end else begin
              at <= at + 2'd1;
            end
          end else begin
            state <= (area[0] == '0) ? S_OUT : S_READ;
          end
        end
        S_READ: begin
          num <= '0;
          at <= '0;
          issue_done <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (!issue_done) begin
            prod <= ProdWidth'(mul_a * mul_b);
            if (at == 2'd2) begin
              issue_done <= 1'b1;
            end else begin
              at <= at + 2'd1;
            end
          end else begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          quo <= num[NumWidth-1] ? NumWidth'(-num) : NumWidth'(num);
          divisor <= area[0][AreaWidth-1] ? AreaWidth'(-area[0]) : AreaWidth'(area[0]);
          neg <= num[NumWidth-1] ^ area[0][AreaWidth-1];
          rem <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, divisor}) begin
            rem <= AreaWidth'(rem_sh - {1'b0, divisor});
            quo <= {quo[NumWidth-2:0], 1'b1};
          end else begin
            rem <= rem_sh[AreaWidth-1:0];
            quo <= {quo[NumWidth-2:0], 1'b0};
          end
          if (32'(step) == DivSteps - 1) begin
            state <= S_OUT;
          end
          step <= step + SW'(1);
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tdata <= {5'd0, 3'(k), sat_val};
            m_axis_tuser <= sat_status;
            m_axis_tlast <= (k + KW'(1) == count);
            k <= k + KW'(1);
            if (k + KW'(1) == count) begin
              state <= S_IDLE;
            end else if (area[0] == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
